@@ design/iirlp_pkg.sv @@
// Shared types, constants and coefficient tables for the three-axis low-pass filter.
`timescale 1ns / 1ps

package iirlp_pkg;

    // Data path sizes
    localparam int AXES        = 3;
    localparam int TAPS        = 6;
    localparam int HIST        = TAPS - 1;
    localparam int SAMPLE_BITS = 24;
    localparam int COEF_W      = 16;
    localparam int COEF_FRAC   = 14;
    localparam int PROD_W      = COEF_W + SAMPLE_BITS;
    // Sum of all coefficient magnitudes stays below 2^17, so sums fit in 42 bits
    localparam int ACC_W       = SAMPLE_BITS + 18;
    localparam int SHIFT_W     = ACC_W - COEF_FRAC;

    // Configuration register file
    localparam int LIMIT_W = 23;
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;
    localparam int INDEX_W = PADDR_W - 2;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET     = 23'd40960;
    localparam logic [INDEX_W-1:0] REG_SPIKE_LIMIT = 2'd0;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic signed [COEF_W-1:0]      coef_t;
    typedef logic signed [PROD_W-1:0]      prod_t;
    typedef logic signed [ACC_W-1:0]       acc_t;
    typedef logic        [LIMIT_W-1:0]     limit_t;

    // Control handed from the sequencer to every cell
    typedef struct packed {
        logic clear;
        logic load;
        logic update;
    } cell_ctrl_t;

    // Butterworth coefficients, signed Q1.14; a0 = 1 is implied
    localparam coef_t COEF_B [TAPS] = '{
        16'sd2130, 16'sd10651, 16'sd21302, 16'sd21302, 16'sd10651, 16'sd2130
    };
    localparam coef_t COEF_A [TAPS] = '{
        16'sd16384, 16'sd20677, 16'sd19543, 16'sd8821, 16'sd2471, 16'sd272
    };

    // Sign-extend a product to accumulator width
    function automatic acc_t widen(input prod_t p);
        return {{(ACC_W - PROD_W){p[PROD_W-1]}}, p};
    endfunction

endpackage

@@ design/three_axis_iir_lowpass_spike_reject.sv @@
// Top level: stream ports, register port, sequencer and the row of filter cells.
// An accepted sample passes samp_reg, acc_reg and out_reg in turn; m_tvalid rises with out_reg.
// A new sample is loaded only after the previous output has gone through the output feedback
// loop (partial sum -> rounded output -> every cell's partial sum); an output stall holds it.
// A tare word passes the first phase only: it clears the cells and yields no output word.
// Reset clears all partial sums and the previous samples and sets spike_limit to 40960.
`timescale 1ns / 1ps

module three_axis_iir_lowpass_spike_reject (
    input  logic                            clk,
    input  logic                            rst_n,
    // APB register port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [iirlp_pkg::PADDR_W-1:0]   paddr,
    input  logic [iirlp_pkg::PDATA_W-1:0]   pwdata,
    output logic [iirlp_pkg::PDATA_W-1:0]   prdata,
    output logic                            pready,
    // Input stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [71:0]                     s_tdata,  // accel_x, accel_y, accel_z
    input  logic [0:0]                      s_tuser,  // command
    // Output stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [71:0]                     m_tdata   // filtered_x, filtered_y, filtered_z
);
    import iirlp_pkg::*;

    localparam acc_t ROUND_HALF = acc_t'(2 ** (COEF_FRAC - 1));
    localparam logic signed [SHIFT_W-1:0] SAT_HI = SHIFT_W'(2 ** (SAMPLE_BITS - 1) - 1);
    localparam logic signed [SHIFT_W-1:0] SAT_LO = ~SAT_HI;

    limit_t     limit_reg;
    logic       cfg_write;
    logic [INDEX_W-1:0] reg_index;

    sample_t    in_sample [AXES];
    sample_t    chosen    [AXES];
    sample_t    prev_reg  [AXES];
    sample_t    samp_reg  [AXES];
    acc_t       acc_reg   [AXES];
    acc_t       acc_next  [AXES];
    acc_t       rounded   [AXES];
    logic signed [SHIFT_W-1:0] shifted [AXES];
    sample_t    y_val     [AXES];
    sample_t    out_reg   [AXES];
    acc_t       chain     [HIST+1][AXES];

    logic       a_valid_reg, a_valid_next;
    logic       a_tare_reg;
    logic       b_valid_reg, b_valid_next;
    logic       out_valid_reg, out_valid_next;
    logic       in_fire, a_go, b_go;
    cell_ctrl_t ctrl;

    // Register port: one register, always ready
    assign reg_index = paddr[PADDR_W-1:2];
    assign cfg_write = psel & penable & pwrite & pready;
    assign pready    = 1'b1;

    always_comb
    begin
        unique case (reg_index)
            REG_SPIKE_LIMIT: prdata = {{(PDATA_W - LIMIT_W){1'b0}}, limit_reg};
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= LIMIT_RESET;
        end
        else if (cfg_write && reg_index == REG_SPIKE_LIMIT)
        begin
            limit_reg <= pwdata[LIMIT_W-1:0];
        end
    end

    // Unpack the input word and reject spikes against the previous sample
    assign in_sample[0] = s_tdata[SAMPLE_BITS-1:0];
    assign in_sample[1] = s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
    assign in_sample[2] = s_tdata[3*SAMPLE_BITS-1:2*SAMPLE_BITS];

    for (genvar g = 0; g < AXES; g++)
    begin : g_spike
        iirlp_spike u_spike (
            .sample (in_sample[g]),
            .prev   (prev_reg[g]),
            .limit  (limit_reg),
            .chosen (chosen[g])
        );
    end

    // Handshake and phase control
    assign s_tready = ~a_valid_reg;
    assign in_fire  = s_tvalid & s_tready;
    assign a_go     = a_valid_reg & ~b_valid_reg;
    assign b_go     = b_valid_reg & (~out_valid_reg | m_tready);

    always_comb
    begin
        ctrl.clear     = a_go & a_tare_reg;
        ctrl.load      = a_go & ~a_tare_reg;
        ctrl.update    = b_go;
        a_valid_next   = in_fire | (a_valid_reg & ~a_go);
        b_valid_next   = ctrl.load | (b_valid_reg & ~b_go);
        out_valid_next = b_go | (out_valid_reg & ~m_tready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg   <= a_valid_next;
            b_valid_reg   <= b_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Track the previous accepted sample; tare drops it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < AXES; i++)
            begin
                prev_reg[i] <= '0;
            end
        end
        else if (in_fire)
        begin
            for (int i = 0; i < AXES; i++)
            begin
                prev_reg[i] <= s_tuser[0] ? '0 : chosen[i];
            end
        end
    end

    // Capture the accepted word
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            a_tare_reg <= s_tuser[0];
            samp_reg   <= chosen;
        end
    end

    // First phase: newest tap plus the partial sum of the first cell
    always_comb
    begin
        for (int i = 0; i < AXES; i++)
        begin
            acc_next[i] = widen(COEF_B[0] * samp_reg[i]) + chain[0][i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            acc_reg <= acc_next;
        end
    end

    // Second phase: round half up, saturate, feed back to the cells
    always_comb
    begin
        for (int i = 0; i < AXES; i++)
        begin
            rounded[i] = acc_reg[i] + ROUND_HALF;
            shifted[i] = rounded[i][ACC_W-1:COEF_FRAC];
            if (shifted[i] > SAT_HI)
            begin
                y_val[i] = SAT_HI[SAMPLE_BITS-1:0];
            end
            else if (shifted[i] < SAT_LO)
            begin
                y_val[i] = SAT_LO[SAMPLE_BITS-1:0];
            end
            else
            begin
                y_val[i] = shifted[i][SAMPLE_BITS-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_go)
        begin
            out_reg <= y_val;
        end
    end

    // Row of cells; the oldest tap sees a zero partial sum
    always_comb
    begin
        for (int i = 0; i < AXES; i++)
        begin
            chain[HIST][i] = '0;
        end
    end

    for (genvar k = 0; k < HIST; k++)
    begin : g_cell
        iirlp_cell u_cell (
            .clk    (clk),
            .rst_n  (rst_n),
            .ctrl   (ctrl),
            .b_coef (COEF_B[k+1]),
            .a_coef (COEF_A[k+1]),
            .x      (samp_reg),
            .y      (y_val),
            .s_in   (chain[k+1]),
            .s_out  (chain[k])
        );
    end

    // Output word
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_reg[2], out_reg[1], out_reg[0]};

endmodule

@@ design/iirlp_spike.sv @@
// Spike rejection for one axis: reuse the previous sample when the step is too large.
`timescale 1ns / 1ps

module iirlp_spike (
    input  iirlp_pkg::sample_t sample,
    input  iirlp_pkg::sample_t prev,
    input  iirlp_pkg::limit_t  limit,
    output iirlp_pkg::sample_t chosen
);
    import iirlp_pkg::*;

    logic signed [SAMPLE_BITS:0] diff;
    logic        [SAMPLE_BITS:0] mag;
    logic        [SAMPLE_BITS:0] limit_ext;

    // Take the absolute step and compare against the limit
    always_comb
    begin
        diff      = {sample[SAMPLE_BITS-1], sample} - {prev[SAMPLE_BITS-1], prev};
        mag       = diff[SAMPLE_BITS] ? $unsigned(-diff) : $unsigned(diff);
        limit_ext = {{(SAMPLE_BITS + 1 - LIMIT_W){1'b0}}, limit};
        chosen    = (mag > limit_ext) ? prev : sample;
    end

endmodule

@@ design/iirlp_cell.sv @@
// One tap of the transposed filter: holds the partial sum for all three axes.
`timescale 1ns / 1ps

module iirlp_cell (
    input  logic                   clk,
    input  logic                   rst_n,
    input  iirlp_pkg::cell_ctrl_t  ctrl,
    input  iirlp_pkg::coef_t       b_coef,
    input  iirlp_pkg::coef_t       a_coef,
    input  iirlp_pkg::sample_t     x     [iirlp_pkg::AXES],
    input  iirlp_pkg::sample_t     y     [iirlp_pkg::AXES],
    input  iirlp_pkg::acc_t        s_in  [iirlp_pkg::AXES],
    output iirlp_pkg::acc_t        s_out [iirlp_pkg::AXES]
);
    import iirlp_pkg::*;

    prod_t prod_b [AXES];
    prod_t prod_a [AXES];
    acc_t  bx_reg [AXES];
    acc_t  bx_next [AXES];
    acc_t  s_reg  [AXES];
    acc_t  s_next [AXES];

    // Feed-forward product now, feedback product once the output is known
    always_comb
    begin
        for (int i = 0; i < AXES; i++)
        begin
            prod_b[i]  = b_coef * x[i];
            prod_a[i]  = a_coef * y[i];
            bx_next[i] = widen(prod_b[i]);
            s_next[i]  = bx_reg[i] - widen(prod_a[i]) + s_in[i];
        end
    end

    // Hold the input product between the two phases
    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            for (int i = 0; i < AXES; i++)
            begin
                bx_reg[i] <= bx_next[i];
            end
        end
    end

    // Advance the partial sum; tare drops it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < AXES; i++)
            begin
                s_reg[i] <= '0;
            end
        end
        else if (ctrl.clear)
        begin
            for (int i = 0; i < AXES; i++)
            begin
                s_reg[i] <= '0;
            end
        end
        else if (ctrl.update)
        begin
            for (int i = 0; i < AXES; i++)
            begin
                s_reg[i] <= s_next[i];
            end
        end
    end

    assign s_out = s_reg;

endmodule

@@ tb/three_axis_iir_lowpass_spike_reject_test.sv @@
// Testbench for the three-axis low-pass filter: predicting scoreboard, stream and register drivers.
`timescale 1ns / 1ps

module three_axis_iir_lowpass_spike_reject_test;

    import iirlp_pkg::PADDR_W;
    import iirlp_pkg::PDATA_W;
    import iirlp_pkg::INDEX_W;
    import iirlp_pkg::REG_SPIKE_LIMIT;
    import iirlp_pkg::limit_t;

    localparam int     AXES           = 3;
    localparam int     FILTER_TAPS    = 6;
    localparam int     HIST_DEPTH     = FILTER_TAPS - 1;
    localparam int     COEF_FRAC      = 14;
    localparam longint ROUND_HALF     = 64'sd8192;
    localparam longint ACCEL_MAX      = 64'sd8388607;
    localparam longint ACCEL_MIN      = -64'sd8388608;
    localparam int     RESET_CYCLES   = 9;
    localparam int     TARE_TAIL      = 4;
    localparam int     END_TAIL       = 8;
    localparam int     WATCHDOG_LIMIT = 1000;
    localparam int     PHASE_WORDS    = 100;

    localparam limit_t DEFAULT_LIMIT = 23'd40960;
    localparam limit_t LIMIT_MAX     = 23'd8388607;

    // Index with no register behind it; writes there must be ignored
    localparam logic [INDEX_W-1:0] REG_SPARE = 2'd2;

    typedef enum logic {
        CMD_SAMPLE = 1'b0,
        CMD_TARE   = 1'b1
    } command_e;

    typedef logic signed [23:0] accel_t;

    // Predicts the filtered words and checks the block's output against them
    class accel_filter_model;
        longint      fwd_coef  [FILTER_TAPS];
        longint      back_coef [FILTER_TAPS];
        limit_t      spike_limit;
        accel_t      past_in   [AXES][HIST_DEPTH];
        accel_t      past_out  [AXES][HIST_DEPTH];
        logic [71:0] pending   [$];
        int unsigned mismatches;
        int unsigned samples;
        int unsigned tares;
        int unsigned spikes;
        int unsigned saturations;

        function void clear_history();
            for (int a = 0; a < AXES; a++)
                for (int i = 0; i < HIST_DEPTH; i++)
                begin
                    past_in[a][i]  = '0;
                    past_out[a][i] = '0;
                end
        endfunction

        function void power_up();
            fwd_coef    = '{2130, 10651, 21302, 21302, 10651, 2130};
            back_coef   = '{16384, 20677, 19543, 8821, 2471, 272};
            spike_limit = DEFAULT_LIMIT;
            mismatches  = 0;
            samples     = 0;
            tares       = 0;
            spikes      = 0;
            saturations = 0;
            clear_history();
        endfunction

        function void set_register(logic [INDEX_W-1:0] index, logic [PDATA_W-1:0] value);
            if (index == REG_SPIKE_LIMIT)
                spike_limit = value[22:0];
        endfunction

        // Spike gate, then one step of the direct-form-I recursion for one axis
        function accel_t filter_axis(int ax, accel_t raw);
            longint acc;
            longint diff;
            accel_t kept;
            accel_t y;
            kept = raw;
            diff = longint'(raw) - longint'(past_in[ax][0]);
            if (diff < 0)
                diff = -diff;
            if (diff > longint'(spike_limit))
            begin
                kept = past_in[ax][0];
                spikes++;
            end
            acc = fwd_coef[0] * longint'(kept);
            for (int i = 1; i < FILTER_TAPS; i++)
                acc += fwd_coef[i] * longint'(past_in[ax][i-1])
                     - back_coef[i] * longint'(past_out[ax][i-1]);
            acc = (acc + ROUND_HALF) >>> COEF_FRAC;
            if (acc > ACCEL_MAX)
            begin
                y = accel_t'(ACCEL_MAX);
                saturations++;
            end
            else if (acc < ACCEL_MIN)
            begin
                y = accel_t'(ACCEL_MIN);
                saturations++;
            end
            else
                y = accel_t'(acc);
            for (int i = HIST_DEPTH - 1; i > 0; i--)
            begin
                past_in[ax][i]  = past_in[ax][i-1];
                past_out[ax][i] = past_out[ax][i-1];
            end
            past_in[ax][0]  = kept;
            past_out[ax][0] = y;
            return y;
        endfunction

        // Record an accepted input word and queue the word it should produce
        function void note_word(command_e cmd, accel_t x, accel_t y, accel_t z);
            logic [71:0] want;
            accel_t      raw [AXES];
            if (cmd == CMD_TARE)
            begin
                clear_history();
                tares++;
                return;
            end
            raw = '{x, y, z};
            for (int a = 0; a < AXES; a++)
                want[24*a +: 24] = filter_axis(a, raw[a]);
            pending.push_back(want);
            samples++;
        endfunction

        task report(string what);
            if (mismatches < 20)
                $display("%0t ns: MISMATCH %s", $time, what);
            mismatches++;
        endtask

        // Compare an output word field by field with the oldest prediction
        task check_word(logic [71:0] word);
            logic [71:0] want;
            if (pending.size() == 0)
            begin
                report($sformatf("output word %h with nothing pending", word));
                return;
            end
            want = pending.pop_front();
            for (int a = 0; a < AXES; a++)
                if (word[24*a +: 24] !== want[24*a +: 24])
                    report($sformatf("filtered axis %0d: got %0d, want %0d", a,
                                     accel_t'(word[24*a +: 24]), accel_t'(want[24*a +: 24])));
        endtask
    endclass

    logic                 clk      = 1'b0;
    logic                 rst_n    = 1'b0;
    logic                 psel     = 1'b0;
    logic                 penable  = 1'b0;
    logic                 pwrite   = 1'b0;
    logic [PADDR_W-1:0]   paddr    = '0;
    logic [PDATA_W-1:0]   pwdata   = '0;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [71:0]          s_tdata  = '0;  // accel_x, accel_y, accel_z
    logic [0:0]           s_tuser  = '0;  // command
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [71:0]          m_tdata;        // filtered_x, filtered_y, filtered_z

    accel_filter_model model;
    int unsigned       burst_left     = 1;
    int unsigned       limit_settings = 0;
    int unsigned       quiet          = 0;
    logic [5:0]        rx_phase       = '0;
    logic [15:0]       rx_pattern     = '1;

    three_axis_iir_lowpass_spike_reject uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Stall the output on a random pattern that changes each time rx_phase wraps
    always @(posedge clk)
    begin
        rx_phase <= rx_phase + 6'd1;
        if (rx_phase == '0)
            rx_pattern <= ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom | 1);
        m_tready <= rx_pattern[rx_phase[3:0]];
    end

    // Check every output word
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            model.check_word(m_tdata);
    end

    // End the run if no word moves for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet <= 0;
            else if (quiet >= WATCHDOG_LIMIT)
            begin
                $display("%0t ns: no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("three_axis_iir_lowpass_spike_reject test failed");
                $finish;
            end
            else
                quiet <= quiet + 1;
        end
    end

    // Hold the input idle for a random gap at the end of each burst
    task automatic pace();
        int unsigned gap;
        burst_left--;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic send_word(command_e cmd, accel_t x, accel_t y, accel_t z);
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {z, y, x};
        do @(posedge clk); while (!s_tready);
        model.note_word(cmd, x, y, z);
        pace();
    endtask

    task automatic send_tare();
        send_word(CMD_TARE, accel_t'($urandom), accel_t'($urandom), accel_t'($urandom));
    endtask

    // Stop sending and wait until every predicted word has come out
    task automatic drain();
        s_tvalid <= 1'b0;
        while (model.pending.size() != 0)
            @(posedge clk);
        repeat (TARE_TAIL) @(posedge clk);
    endtask

    task automatic write_register(logic [INDEX_W-1:0] index, logic [PDATA_W-1:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        model.set_register(index, value);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic read_back(logic [INDEX_W-1:0] index, limit_t value);
        logic [PDATA_W-1:0] got;
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {index, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        got = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (got !== PDATA_W'(value))
            model.report($sformatf("spike_limit read %0d, want %0d", got, value));
    endtask

    task automatic set_limit(limit_t value);
        drain();
        write_register(REG_SPIKE_LIMIT, PDATA_W'(value));
        read_back(REG_SPIKE_LIMIT, value);
        limit_settings++;
    endtask

    // Mostly a walk within the spike limit, some exact-boundary steps and some wild values
    function automatic accel_t next_value(int ax);
        longint      last;
        longint      v;
        int unsigned lim;
        int unsigned pick;
        last = longint'(model.past_in[ax][0]);
        lim  = {9'd0, model.spike_limit};
        pick = $urandom_range(0, 99);
        if (pick < 70)
            v = last + longint'($urandom_range(0, 2 * lim)) - longint'(lim);
        else if (pick < 85)
        begin
            v = longint'(lim) + longint'($urandom_range(0, 1));
            v = $urandom_range(0, 1) ? last + v : last - v;
        end
        else if (pick < 95)
            v = longint'(accel_t'($urandom));
        else
            case ($urandom_range(0, 3))
                0:       v = ACCEL_MAX;
                1:       v = ACCEL_MIN;
                2:       v = 0;
                default: v = -1;
            endcase
        if (v > ACCEL_MAX)
            v = ACCEL_MAX;
        if (v < ACCEL_MIN)
            v = ACCEL_MIN;
        return accel_t'(v);
    endfunction

    task automatic random_word();
        accel_t x;
        accel_t y;
        accel_t z;
        if ($urandom_range(0, 24) == 0)
            send_tare();
        else
        begin
            x = next_value(0);
            y = next_value(1);
            z = next_value(2);
            send_word(CMD_SAMPLE, x, y, z);
        end
        if ($urandom_range(0, 99) == 0)
            drain();
    endtask

    initial
    begin
        limit_t phase_limits [5];
        model = new;
        model.power_up();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset value of the limit, then spikes around it
        read_back(REG_SPIKE_LIMIT, DEFAULT_LIMIT);
        send_word(CMD_SAMPLE, 24'sd100, -24'sd200, 24'sd300);
        send_word(CMD_SAMPLE, 24'sd41061, 24'sd40760, -24'sd40661);
        send_word(CMD_SAMPLE, accel_t'(ACCEL_MIN), accel_t'(ACCEL_MAX), 24'sd0);
        send_tare();
        // First sample after a tare is measured against zero
        send_word(CMD_SAMPLE, 24'sd40961, -24'sd40960, accel_t'(ACCEL_MAX));
        send_tare();
        send_tare();
        send_word(CMD_SAMPLE, 24'sd0, 24'sd0, 24'sd0);

        // Full-scale steps with the widest limit drive the output into saturation
        drain();
        write_register(REG_SPARE, $urandom);
        set_limit(LIMIT_MAX);
        for (int k = 0; k < 8; k++)
            send_word(CMD_SAMPLE, accel_t'(ACCEL_MAX),
                      (k == 0) ? -24'sd8388607 : accel_t'(ACCEL_MIN), accel_t'(k * 1000));
        send_word(CMD_SAMPLE, 24'sd0, 24'sd0, 24'sd0);
        send_word(CMD_SAMPLE, 24'sd0, 24'sd0, 24'sd0);

        // Zero limit: only an unchanged sample gets through
        set_limit('0);
        send_word(CMD_SAMPLE, 24'sd0, 24'sd1, -24'sd1);
        send_word(CMD_SAMPLE, 24'sd5, 24'sd5, 24'sd5);
        send_word(CMD_SAMPLE, 24'sd0, accel_t'(ACCEL_MIN), 24'sd0);

        // Random phases, one per limit setting
        phase_limits = '{DEFAULT_LIMIT, limit_t'($urandom), '0, LIMIT_MAX,
                         limit_t'($urandom_range(1, 255))};
        for (int p = 0; p < 5; p++)
        begin
            set_limit(phase_limits[p]);
            for (int n = 0; n < PHASE_WORDS; n++)
                random_word();
        end

        drain();
        repeat (END_TAIL) @(posedge clk);
        $display("covered %0d samples and %0d tares over %0d limit settings (zero and full scale)",
                 model.samples, model.tares, limit_settings);
        $display("%0d axis values rejected as spikes, %0d outputs saturated",
                 model.spikes, model.saturations);
        if (model.mismatches == 0 && model.pending.size() == 0)
            $display("three_axis_iir_lowpass_spike_reject test passed");
        else
            $display("three_axis_iir_lowpass_spike_reject test failed");
        $finish;
    end

endmodule
